// ----- rtl/sound_triggered_relay_sequencer_unit_assert.svh -----
// Assertion macros for the sound triggered relay sequencer.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SOUND_TRIGGERED_RELAY_SEQUENCER_UNIT_ASSERT_SVH
`define SOUND_TRIGGERED_RELAY_SEQUENCER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Combinational property checked at every clock edge out of reset.
`define STSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define STSR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define STSR_ASSERT(lbl, prop, msg)
`define STSR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/stsr_pkg.sv -----
// Package for the sound triggered relay sequencer: codes, config and result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stsr_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SAMPLE     = 2'd1,
    CMD_PEER_START = 2'd2,
    CMD_PEER_STOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_LISTEN = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_GEN    = 2'd2,
    MODE_REST   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    LAMP_OFF        = 2'd0,
    LAMP_WAITING    = 2'd1,
    LAMP_DETECTED   = 2'd2,
    LAMP_GENERATING = 2'd3
  } lamp_e;

  typedef enum logic [1:0] {
    ANN_NONE  = 2'd0,
    ANN_START = 2'd1,
    ANN_STOP  = 2'd2
  } announce_e;

  // register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_MIC_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STRICT_CHECK  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DETECT_WAIT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REST_TICKS    = 3'd4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [9:0]  RST_MIC_THRESHOLD = 10'd8;
  localparam logic [5:0]  RST_WINDOW_WIDTH  = 6'd4;
  localparam logic        RST_STRICT_CHECK  = 1'b1;
  localparam logic [15:0] RST_DETECT_WAIT   = 16'd0;
  localparam logic [15:0] RST_REST_TICKS    = 16'd500;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [2:0]  PICK_MAX = 3'd4;

  typedef struct packed {
    logic [9:0]  mic_threshold;
    logic [5:0]  window_width;
    logic        strict_check;
    logic [15:0] detect_wait_ticks;
    logic [15:0] rest_ticks;
  } cfg_t;

  typedef struct packed {
    announce_e announce;
    mode_e     mode;
    lamp_e     lamp_level;
    logic      relay_on;
  } res_t;

  // relay closing length per sound; picks above the table use its last entry
  function automatic logic [1:0] on_ticks_of(input logic [2:0] pick);
    logic [1:0] r;
    case (pick)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/stsr_cfg_regs.sv -----
// Configuration register file of the sound triggered relay sequencer.
// Depends on stsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stsr_cfg_regs (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 wr_en_i,
  input  wire  [stsr_pkg::CfgIdxW-1:0]        idx_i,
  input  wire  [stsr_pkg::CfgDataW-1:0]       wdata_i,
  output stsr_pkg::cfg_t                      cfg_o
);
  import stsr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (idx_i)
        REG_MIC_THRESHOLD: cfg_d.mic_threshold     = wdata_i[9:0];
        REG_WINDOW_WIDTH:  cfg_d.window_width      = wdata_i[5:0];
        REG_STRICT_CHECK:  cfg_d.strict_check      = wdata_i[0];
        REG_DETECT_WAIT:   cfg_d.detect_wait_ticks = wdata_i[15:0];
        REG_REST_TICKS:    cfg_d.rest_ticks        = wdata_i[15:0];
        default:           cfg_d = cfg_q;  // out-of-list index dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mic_threshold     <= RST_MIC_THRESHOLD;
      cfg_q.window_width      <= RST_WINDOW_WIDTH;
      cfg_q.strict_check      <= RST_STRICT_CHECK;
      cfg_q.detect_wait_ticks <= RST_DETECT_WAIT;
      cfg_q.rest_ticks        <= RST_REST_TICKS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/stsr_step.sv -----
// Sequencer state and single-pass next-state logic for one command beat.
// Depends on stsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stsr_step #(
  parameter int unsigned PEER_COUNT_MAX = 15
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  stsr_pkg::cmd_e        cmd_i,
  input  wire  [9:0]            sample_i,
  input  wire  [2:0]            pick_i,
  input  stsr_pkg::cfg_t        cfg_i,
  output stsr_pkg::res_t        res_o
);
  import stsr_pkg::*;

  localparam int unsigned InhW = $clog2(PEER_COUNT_MAX + 1);
  localparam logic [InhW-1:0] InhMax = InhW'(PEER_COUNT_MAX);

  mode_e           mode_q, mode_d;
  lamp_e           lamp_q, lamp_d;
  logic            prime_q, prime_d;
  logic            confirm_q, confirm_d;
  logic [9:0]      last_q, last_d;
  logic [InhW-1:0] inh_q, inh_d;
  logic [15:0]     tick_q, tick_d;
  logic [1:0]      on_q, on_d;
  announce_e       ann;

  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic [9:0]  jump;
  logic [10:0] win_top;
  logic        hit;
  logic        detect;

  always_comb begin
    tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 16'd1;
    case (mode_q)
      MODE_WAIT: limit = cfg_i.detect_wait_ticks;
      MODE_GEN:  limit = {14'd0, on_q};
      default:   limit = cfg_i.rest_ticks;
    endcase
    jump    = (sample_i >= last_q) ? sample_i - last_q : last_q - sample_i;
    win_top = {1'b0, cfg_i.mic_threshold} + {5'd0, cfg_i.window_width};
    hit     = (jump > cfg_i.mic_threshold) && ({1'b0, jump} < win_top);
  end

  always_comb begin
    mode_d    = mode_q;
    lamp_d    = lamp_q;
    prime_d   = prime_q;
    confirm_d = confirm_q;
    last_d    = last_q;
    inh_d     = inh_q;
    tick_d    = tick_q;
    on_d      = on_q;
    ann       = ANN_NONE;
    detect    = 1'b0;
    case (cmd_i)
      CMD_TICK: begin
        if (mode_q != MODE_LISTEN) begin
          if (limit > tick_inc) begin
            tick_d = tick_inc;
          end else begin
            tick_d = 16'd0;
            case (mode_q)
              MODE_WAIT: begin
                mode_d = MODE_GEN;
                lamp_d = LAMP_GENERATING;
              end
              MODE_GEN: begin
                mode_d = MODE_REST;
                lamp_d = LAMP_OFF;
                ann    = ANN_STOP;
              end
              default: begin
                mode_d    = MODE_LISTEN;
                lamp_d    = LAMP_WAITING;
                prime_d   = 1'b1;
                confirm_d = 1'b0;
              end
            endcase
          end
        end
      end
      CMD_SAMPLE: begin
        if (mode_q == MODE_LISTEN && inh_q == '0) begin
          last_d = sample_i;
          if (prime_q) begin
            prime_d = 1'b0;
          end else if (confirm_q) begin
            confirm_d = 1'b0;
            detect    = hit;
          end else if (hit) begin
            if (cfg_i.strict_check) confirm_d = 1'b1;
            else detect = 1'b1;
          end
          if (detect) begin
            mode_d = MODE_WAIT;
            tick_d = 16'd0;
            on_d   = on_ticks_of((pick_i > PICK_MAX) ? PICK_MAX : pick_i);
            lamp_d = LAMP_DETECTED;
            ann    = ANN_START;
          end
        end
      end
      CMD_PEER_START: begin
        if (inh_q < InhMax) inh_d = inh_q + 1'b1;
      end
      default: begin
        if (inh_q != '0) inh_d = inh_q - 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_LISTEN;
      lamp_q    <= LAMP_WAITING;
      prime_q   <= 1'b1;
      confirm_q <= 1'b0;
      last_q    <= 10'd0;
      inh_q     <= '0;
      tick_q    <= 16'd0;
      on_q      <= 2'd0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      lamp_q    <= lamp_d;
      prime_q   <= prime_d;
      confirm_q <= confirm_d;
      last_q    <= last_d;
      inh_q     <= inh_d;
      tick_q    <= tick_d;
      on_q      <= on_d;
    end
  end

  assign res_o.announce   = ann;
  assign res_o.mode       = mode_d;
  assign res_o.lamp_level = lamp_d;
  assign res_o.relay_on   = (mode_d == MODE_GEN);

endmodule
`default_nettype wire

// ----- rtl/sound_triggered_relay_sequencer_unit.sv -----
// Top level of the sound triggered relay sequencer: input beat register,
// step logic, result register. Depends on stsr_pkg, stsr_cfg_regs, stsr_step.
//
//  channel  | direction | beat fields (low bit up)
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: sample, pick
//  m_axis   | out       | tdata: relay_on, lamp_level, mode, announce
//  cfg      | in        | write enable, register index, write data
//
// Each command beat passes from the input register through the step logic
// into the result register, which presents it as a valid result; a new beat
// is taken every cycle while m_axis does not stall. Throughput is set by the
// single step stage between the input and result registers. Reset clears all
// control and sequencer state at once; no clearing pass. When m_axis stalls,
// the result register holds and one more beat parks in the input register
// before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module sound_triggered_relay_sequencer_unit #(
  parameter int unsigned PEER_COUNT_MAX = 15
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // input command stream
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [15:0]                    s_axis_tdata,   // sample[9:0], pick[12:10], zero pad
  input  wire  [1:0]                     s_axis_tuser,   // command[1:0]
  // result stream
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // relay_on, lamp_level, mode,
                                                         // announce, zero pad
  // configuration writes
  input  wire                            cfg_wr_en_i,
  input  wire  [stsr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [stsr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import stsr_pkg::*;

  cfg_t cfg;
  res_t res;

  // input beat register
  logic       in_valid_q, in_valid_d;
  cmd_e       in_cmd_q;
  logic [9:0] in_sample_q;
  logic [2:0] in_pick_q;

  // result register
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;

  logic s_accept;
  logic advance;  // input beat moves through the step logic this cycle

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept)     in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)            out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_cmd_q    <= cmd_e'(s_axis_tuser);
      in_sample_q <= s_axis_tdata[9:0];
      in_pick_q   <= s_axis_tdata[12:10];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  stsr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_wr_en_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  stsr_step #(
    .PEER_COUNT_MAX (PEER_COUNT_MAX)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .cmd_i    (in_cmd_q),
    .sample_i (in_sample_q),
    .pick_i   (in_pick_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.announce, out_res_q.mode,
                          out_res_q.lamp_level, out_res_q.relay_on};

`include "sound_triggered_relay_sequencer_unit_assert.svh"

  // relay drives exactly while generating
  `STSR_ASSERT(a_relay_mode, !out_valid_q || (out_res_q.relay_on == (out_res_q.mode == MODE_GEN)), "relay level disagrees with mode")
  // a start announcement comes only with entry into detected wait
  `STSR_ASSERT(a_start_wait, !out_valid_q || out_res_q.announce != ANN_START || (out_res_q.mode == MODE_WAIT && out_res_q.lamp_level == LAMP_DETECTED), "start announced outside detected wait")
  // an accepted beat is parked in the input register next cycle
  `STSR_ASSERT_NEXT(a_in_park, s_accept, in_valid_q, "accepted beat lost")
  // a beat through the step logic shows as a valid result next cycle
  `STSR_ASSERT_NEXT(a_out_load, advance, out_valid_q, "stepped beat not presented")

endmodule
`default_nettype wire

// ----- tb/sound_triggered_relay_sequencer_unit_test.sv -----
// Testbench for sound_triggered_relay_sequencer_unit: directed and random command streams,
// each result beat checked against a cycle-free model of the listener sequencer.
// Depends on stsr_pkg and the unit top level only.
`timescale 1ns / 1ps
module sound_triggered_relay_sequencer_unit_test;
  import stsr_pkg::*;

  localparam int unsigned PEER_MAX    = 15;
  localparam int unsigned CYCLE_LIMIT = 500000;
  // relay closing length per sound, entry 0 in the low bits
  localparam logic [9:0]  RELAY_LEN   = {2'd3, 2'd1, 2'd2, 2'd1, 2'd1};

  logic clk_i;
  logic rst_ni;

  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;   // sample[9:0], pick[12:10], zero pad
  logic [1:0]          s_axis_tuser;   // command[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // relay_on, lamp_level[2:1], mode[4:3], announce[6:5]
  logic                cfg_wr_en_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sound_triggered_relay_sequencer_unit #(
    .PEER_COUNT_MAX(PEER_MAX)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the registers and of the sequencer state
  // ---------------------------------------------------------------------------
  logic [9:0]  cfg_thr    = RST_MIC_THRESHOLD;
  logic [5:0]  cfg_width  = RST_WINDOW_WIDTH;
  logic        cfg_strict = RST_STRICT_CHECK;
  logic [15:0] cfg_wait   = RST_DETECT_WAIT;
  logic [15:0] cfg_rest   = RST_REST_TICKS;

  mode_e       sq_mode     = MODE_LISTEN;
  lamp_e       sq_lamp     = LAMP_WAITING;
  bit          sq_prime    = 1'b1;
  bit          sq_confirm  = 1'b0;
  logic [9:0]  sq_last     = '0;
  int unsigned sq_inhibit  = 0;
  logic [15:0] sq_ticks    = '0;
  logic [1:0]  sq_on_ticks = '0;

  res_t        relay_expect_q[$];   // expected result beats, oldest first
  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;

  // idling controls for the sender and for the receiver
  bit          tx_idle_en     = 1'b1;
  bit          rx_idle_en     = 1'b1;
  int unsigned rx_hold_cycles = 0;

  // random sample and pick of field width
  function automatic logic [9:0] rand_smp();
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [2:0] rand_pick();
    return 3'($urandom_range(0, 7));
  endfunction

  // Advance the shadow sequencer by one command; returns the result beat it causes.
  function automatic res_t sequencer_step(cmd_e cmd, logic [9:0] smp, logic [2:0] pick);
    res_t        r;
    announce_e   note;
    logic [15:0] lim;
    int          a;
    int          b;
    int          jump;
    bit          hit;
    bit          detect;
    logic [2:0]  p;
    note   = ANN_NONE;
    detect = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (sq_mode != MODE_LISTEN) begin
          if (sq_ticks != TICK_MAX) sq_ticks++;
          case (sq_mode)
            MODE_WAIT: lim = cfg_wait;
            MODE_GEN:  lim = {14'd0, sq_on_ticks};
            default:   lim = cfg_rest;
          endcase
          // a mode ends once its limit no longer exceeds the count
          if (lim <= sq_ticks) begin
            sq_ticks = '0;
            case (sq_mode)
              MODE_WAIT: begin
                sq_mode = MODE_GEN;
                sq_lamp = LAMP_GENERATING;
              end
              MODE_GEN: begin
                sq_mode = MODE_REST;
                sq_lamp = LAMP_OFF;
                note    = ANN_STOP;
              end
              default: begin
                sq_mode    = MODE_LISTEN;
                sq_lamp    = LAMP_WAITING;
                sq_prime   = 1'b1;
                sq_confirm = 1'b0;
              end
            endcase
          end
        end
      end
      CMD_SAMPLE: begin
        if (sq_mode == MODE_LISTEN && sq_inhibit == 0) begin
          if (sq_prime) begin
            sq_prime = 1'b0;
            sq_last  = smp;
          end else begin
            a    = int'(smp);
            b    = int'(sq_last);
            jump = (a >= b) ? a - b : b - a;
            hit  = (jump > int'(cfg_thr)) && (jump < int'(cfg_thr) + int'(cfg_width));
            sq_last = smp;
            if (sq_confirm) begin
              sq_confirm = 1'b0;
              detect     = hit;
            end else if (hit) begin
              if (cfg_strict) sq_confirm = 1'b1;
              else detect = 1'b1;
            end
            if (detect) begin
              p           = (pick > PICK_MAX) ? PICK_MAX : pick;
              sq_mode     = MODE_WAIT;
              sq_ticks    = '0;
              sq_on_ticks = RELAY_LEN[p*2 +: 2];
              sq_lamp     = LAMP_DETECTED;
              note        = ANN_START;
            end
          end
        end
      end
      CMD_PEER_START: if (sq_inhibit < PEER_MAX) sq_inhibit++;
      default:        if (sq_inhibit > 0) sq_inhibit--;
    endcase
    r.relay_on   = (sq_mode == MODE_GEN);
    r.lamp_level = sq_lamp;
    r.mode       = sq_mode;
    r.announce   = note;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: receiver with random stalls, and the beat checker
  // ---------------------------------------------------------------------------
  // The receiver draws a stall per beat; a long hold-off requested by a test is
  // added on top and counted here, so the unit fills up and drops s_axis_tready.
  initial begin : result_receiver
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall          = (rx_idle_en ? $urandom_range(0, 9) : 0) + rx_hold_cycles;
      rx_hold_cycles = 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Values read right after the edge are the ones the handshake saw.
  res_t seen_beat;
  res_t due_beat;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_beat = res_t'(m_axis_tdata[6:0]);
      if (relay_expect_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        due_beat = relay_expect_q.pop_front();
        if (seen_beat.relay_on !== due_beat.relay_on) begin
          $error("relay_on: expected %0d, got %0d", due_beat.relay_on, seen_beat.relay_on);
          fail_cnt++;
        end
        if (seen_beat.lamp_level !== due_beat.lamp_level) begin
          $error("lamp_level: expected %0d, got %0d", due_beat.lamp_level,
                 seen_beat.lamp_level);
          fail_cnt++;
        end
        if (seen_beat.mode !== due_beat.mode) begin
          $error("mode: expected %0d, got %0d", due_beat.mode, seen_beat.mode);
          fail_cnt++;
        end
        if (seen_beat.announce !== due_beat.announce) begin
          $error("announce: expected %0d, got %0d", due_beat.announce, seen_beat.announce);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // Offer one command beat after a random gap; returns at the accepting edge with
  // tvalid still high, so back-to-back beats need no low cycle between them.
  task automatic send_cmd(input cmd_e cmd, input logic [9:0] smp, input logic [2:0] pick);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, pick, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    relay_expect_q.push_back(sequencer_step(cmd, smp, pick));
  endtask

  // Stop offering and let every outstanding result come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (relay_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; only called with the unit idle. Drops the enable before it
  // returns so that back-to-back writes never touch the enable twice in one step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_wr_en_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    case (idx)
      REG_MIC_THRESHOLD: cfg_thr    = val[9:0];
      REG_WINDOW_WIDTH:  cfg_width  = val[5:0];
      REG_STRICT_CHECK:  cfg_strict = val[0];
      REG_DETECT_WAIT:   cfg_wait   = val;
      REG_REST_TICKS:    cfg_rest   = val;
      default: ;  // indexes past the list are dropped
    endcase
    @(posedge clk_i);
  endtask

  // One random stimulus step, shaped by the shadow state. In listen most samples
  // land a jump inside (or right on the edge of) the window so detections happen;
  // now and then a peer episode pushes the inhibit count up and back down.
  task automatic send_random(output int unsigned beats);
    int unsigned r;
    int unsigned n;
    int          jmp;
    int          tgt;
    int          last_i;
    int          w;
    bit          up;
    r     = $urandom_range(0, 99);
    beats = 1;
    if (sq_mode == MODE_LISTEN) begin
      if (r < 3) begin
        n = $urandom_range(1, 17);
        repeat (n) send_cmd(CMD_PEER_START, rand_smp(), rand_pick());
        send_cmd(CMD_SAMPLE, rand_smp(), rand_pick());
        repeat (n + 1) send_cmd(CMD_PEER_STOP, rand_smp(), rand_pick());
        beats = 2 * n + 2;
      end else if (r < 60) begin
        w      = int'(cfg_width);
        last_i = int'(sq_last);
        if (w > 1 && $urandom_range(0, 9) != 0) jmp = int'(cfg_thr) + $urandom_range(1, w - 1);
        else jmp = ($urandom_range(0, 1) != 0) ? int'(cfg_thr) : int'(cfg_thr) + w;
        up  = $urandom_range(0, 1);
        tgt = up ? last_i + jmp : last_i - jmp;
        if (tgt > 1023 || tgt < 0) tgt = up ? last_i - jmp : last_i + jmp;
        if (tgt > 1023 || tgt < 0) tgt = (last_i < 512) ? 1023 : 0;
        send_cmd(CMD_SAMPLE, tgt[9:0], rand_pick());
      end else if (r < 75) begin
        send_cmd(CMD_SAMPLE, rand_smp(), rand_pick());
      end else if (r < 85) begin
        send_cmd(CMD_TICK, rand_smp(), rand_pick());
      end else if (r < 92) begin
        send_cmd(CMD_PEER_START, rand_smp(), rand_pick());
      end else begin
        send_cmd(CMD_PEER_STOP, rand_smp(), rand_pick());
      end
    end else begin
      if (r < 75) send_cmd(CMD_TICK, rand_smp(), rand_pick());
      else if (r < 88) send_cmd(CMD_SAMPLE, rand_smp(), rand_pick());
      else if (r < 94) send_cmd(CMD_PEER_START, rand_smp(), rand_pick());
      else send_cmd(CMD_PEER_STOP, rand_smp(), rand_pick());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Out of reset: tick in listen is a no-op, the inhibit count floors at zero,
  // and an inhibited sample is dropped.
  task automatic test_power_up();
    send_cmd(CMD_TICK,       10'd0,   3'd0);
    send_cmd(CMD_PEER_STOP,  10'd0,   3'd0);
    send_cmd(CMD_PEER_START, 10'd0,   3'd0);
    send_cmd(CMD_SAMPLE,     10'd512, 3'd0);
    send_cmd(CMD_PEER_STOP,  10'd0,   3'd0);
  endtask

  // Reset window, strict mode: prime, hit, confirming hit; pick past the table
  // gives the longest closing. Zero detect wait ends on the first tick. Rest is
  // set to its maximum, then shortened mid-count so the next tick ends it.
  task automatic test_strict_detection();
    drain_results();
    write_reg(REG_REST_TICKS, 16'hFFFF);
    send_cmd(CMD_SAMPLE, 10'd1023, 3'd0);
    send_cmd(CMD_SAMPLE, 10'd1013, 3'd0);
    send_cmd(CMD_SAMPLE, 10'd1023, 3'd7);
    repeat (6) send_cmd(CMD_TICK, 10'd0, 3'd0);
    drain_results();
    write_reg(REG_REST_TICKS, 16'd1);
    send_cmd(CMD_TICK, 10'd0, 3'd0);
  endtask

  // Threshold written with junk above its width; a width of one leaves no window;
  // a write past the register list changes nothing. Then a single hit detects in
  // non-strict mode while the detect wait sits at its maximum, cut short mid-count.
  task automatic test_window_edges();
    drain_results();
    write_reg(REG_MIC_THRESHOLD, 16'hFC00);
    write_reg(REG_WINDOW_WIDTH,  16'd1);
    write_reg(REG_STRICT_CHECK,  16'd0);
    write_reg(3'd7,              16'hFFFF);
    send_cmd(CMD_SAMPLE, 10'd0, 3'd0);
    send_cmd(CMD_SAMPLE, 10'd1, 3'd0);
    drain_results();
    write_reg(REG_WINDOW_WIDTH, 16'd2);
    write_reg(REG_DETECT_WAIT,  16'hFFFF);
    send_cmd(CMD_SAMPLE, 10'd0, 3'd2);
    send_cmd(CMD_TICK,   10'd0, 3'd0);
    drain_results();
    write_reg(REG_DETECT_WAIT, 16'd0);
    repeat (4) send_cmd(CMD_TICK, 10'd0, 3'd0);
  endtask

  // Long receiver hold-off with the sender streaming flat out, then a full pause.
  task automatic test_backpressure();
    int unsigned n;
    int unsigned i;
    drain_results();
    write_reg(REG_MIC_THRESHOLD, 16'd3);
    write_reg(REG_WINDOW_WIDTH,  16'd20);
    write_reg(REG_DETECT_WAIT,   16'd1);
    write_reg(REG_REST_TICKS,    16'd2);
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_hold_cycles = 300;
    i = 0;
    while (i < 40) begin
      send_random(n);
      i += n;
    end
    drain_results();
  endtask

  // Random phases, each with its own register setting; the first three hit the
  // extremes (widest window from zero, window at the top of the range with the
  // longest detect wait, largest threshold with an empty window and longest rest).
  task automatic test_random_phases();
    int unsigned ph;
    int unsigned cnt;
    int unsigned n;
    for (ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(REG_MIC_THRESHOLD, 16'd0);
          write_reg(REG_WINDOW_WIDTH,  16'd63);
          write_reg(REG_STRICT_CHECK,  16'd0);
          write_reg(REG_DETECT_WAIT,   16'd0);
          write_reg(REG_REST_TICKS,    16'd0);
        end
        1: begin
          write_reg(REG_MIC_THRESHOLD, 16'd1000);
          write_reg(REG_WINDOW_WIDTH,  16'd63);
          write_reg(REG_STRICT_CHECK,  16'd1);
          write_reg(REG_DETECT_WAIT,   16'hFFFF);
          write_reg(REG_REST_TICKS,    16'd2);
        end
        2: begin
          write_reg(REG_MIC_THRESHOLD, 16'd1023);
          write_reg(REG_WINDOW_WIDTH,  16'd0);
          write_reg(REG_STRICT_CHECK,  16'd0);
          write_reg(REG_DETECT_WAIT,   16'd3);
          write_reg(REG_REST_TICKS,    16'hFFFF);
        end
        default: begin
          write_reg(REG_MIC_THRESHOLD, {6'($urandom), 10'($urandom_range(0, 60))});
          write_reg(REG_WINDOW_WIDTH,  16'($urandom_range(0, 63)));
          write_reg(REG_STRICT_CHECK,  16'($urandom));
          write_reg(REG_DETECT_WAIT,   16'($urandom_range(0, 5)));
          write_reg(REG_REST_TICKS,    16'($urandom_range(0, 12)));
        end
      endcase
      // phase 0 runs with no idling at all; the rest pick idling per side
      tx_idle_en = (ph != 0) && ($urandom_range(0, 2) != 0);
      rx_idle_en = (ph != 0) && ($urandom_range(0, 2) != 0);
      cnt = 0;
      while (cnt < 220) begin
        send_random(n);
        cnt += n;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_wr_en_i   <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up();
    test_strict_detection();
    test_window_edges();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sound_triggered_relay_sequencer_unit.f -----
+incdir+rtl
rtl/stsr_pkg.sv
rtl/stsr_cfg_regs.sv
rtl/stsr_step.sv
rtl/sound_triggered_relay_sequencer_unit.sv
tb/sound_triggered_relay_sequencer_unit_test.sv
